// File: rtl/sqmm_pkg.sv
// shared constants, types and command structs for the square matrix multiplier
`timescale 1ns / 1ps

package sqmm_pkg;

	localparam int MAX_DIM     = 4;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 2;
	localparam int DIM_W       = 3;
	localparam int REQ_W       = 2;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int IN_TDATA_W  = ((2 * IDX_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * IDX_W + DATA_W + 7) / 8) * 8;

	localparam logic [REQ_W-1:0] REQ_WR_FIRST  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WR_SECOND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_COMPUTE   = 2'd2;

	localparam logic [DIM_W-1:0] SIZE_RESET = 3'd4;

	typedef struct packed {
		logic             wr_first;
		logic             wr_second;
		logic             issue;
		logic             acc_clear;
		logic             load_out;
		logic             last;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] k;
	} sqmm_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} sqmm_stat_t;

endpackage

// File: rtl/square_matrix_multiply.sv
// square matrix multiply: write beats load element stores, a compute beat streams the product
// writes: a write beat is accepted while idle, and the input stays ready for the next beat
// compute: each product element takes n reads and multiply-accumulates on the
// shared multiplier, a drain of the read and multiply stages and an output state;
// a run covers n*n elements, and the input stalls meanwhile
// reset: control state clears and matrix_size returns to 4; stores hold garbage until written
`timescale 1ns / 1ps

module square_matrix_multiply (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sqmm_pkg::IN_TDATA_W-1:0]  s_tdata,  // row_index, col_index, element_value
	input  logic [sqmm_pkg::REQ_W-1:0]       s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sqmm_pkg::OUT_TDATA_W-1:0] m_tdata,  // out_row, out_col, product_value
	output logic                            m_tuser,  // saturated
	output logic                            m_tlast,  // last_element
	input  logic                            cfg_we,
	input  logic [sqmm_pkg::DIM_W-1:0]       cfg_wdata // matrix_size
);

	import sqmm_pkg::*;

	sqmm_cmd_t         cmd;
	sqmm_stat_t        stat;
	logic [IDX_W-1:0]  out_row;
	logic [IDX_W-1:0]  out_col;
	logic [DATA_W-1:0] product_value;

	sqmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	sqmm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.wr_row       (s_tdata[IDX_W-1:0]),
		.wr_col       (s_tdata[2*IDX_W-1:IDX_W]),
		.wr_data      (s_tdata[2*IDX_W+DATA_W-1:2*IDX_W]),
		.out_row      (out_row),
		.out_col      (out_col),
		.product_value(product_value),
		.saturated    (m_tuser),
		.last_element (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W-2*IDX_W-DATA_W){1'b0}}, product_value, out_col, out_row};

endmodule

// File: rtl/sqmm_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module sqmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sqmm_ctrl.sv
// controller: handshakes, size register, row/column/k sequencing
`timescale 1ns / 1ps

module sqmm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [sqmm_pkg::REQ_W-1:0] req_type,
	input  logic                      cfg_we,
	input  logic [sqmm_pkg::DIM_W-1:0] cfg_wdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output sqmm_pkg::sqmm_cmd_t       cmd,
	input  sqmm_pkg::sqmm_stat_t      stat
);

	import sqmm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] size_q;
	logic [DIM_W-1:0] n_q;
	logic [IDX_W-1:0] r_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W-1:0] k_q;
	logic [DIM_W-1:0] n_clamped;
	logic             accept;
	logic             k_last;
	logic             r_last;
	logic             c_last;

	always_comb begin
		if (size_q == '0) begin
			n_clamped = DIM_W'(1);
		end else if (size_q > DIM_W'(MAX_DIM)) begin
			n_clamped = DIM_W'(MAX_DIM);
		end else begin
			n_clamped = size_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign accept   = s_tvalid && s_tready;
	assign k_last   = (DIM_W'(k_q) == n_q - DIM_W'(1));
	assign r_last   = (DIM_W'(r_q) == n_q - DIM_W'(1));
	assign c_last   = (DIM_W'(c_q) == n_q - DIM_W'(1));

	always_comb begin
		cmd           = '0;
		cmd.r         = r_q;
		cmd.c         = c_q;
		cmd.k         = k_q;
		cmd.last      = r_last && c_last;
		cmd.wr_first  = accept && (req_type == REQ_WR_FIRST);
		cmd.wr_second = accept && (req_type == REQ_WR_SECOND);
		cmd.issue     = (state_q == ST_ISSUE);
		cmd.load_out  = (state_q == ST_DRAIN) && !stat.pipe_busy;
		cmd.acc_clear = cmd.load_out || (accept && (req_type == REQ_COMPUTE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= DIM_W'(1);
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_COMPUTE)) begin
						n_q     <= n_clamped;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					// wait for the read and multiply stages to empty into the accumulator
					if (!stat.pipe_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						if (r_last && c_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (c_last) begin
								c_q <= '0;
								r_q <= r_q + IDX_W'(1);
							end else begin
								c_q <= c_q + IDX_W'(1);
							end
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/sqmm_datapath.sv
// datapath: matrix stores, multiply-accumulate pipeline, saturation and output register
`timescale 1ns / 1ps

module sqmm_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sqmm_pkg::sqmm_cmd_t        cmd,
	output sqmm_pkg::sqmm_stat_t       stat,
	input  logic [sqmm_pkg::IDX_W-1:0]  wr_row,
	input  logic [sqmm_pkg::IDX_W-1:0]  wr_col,
	input  logic [sqmm_pkg::DATA_W-1:0] wr_data,
	output logic [sqmm_pkg::IDX_W-1:0]  out_row,
	output logic [sqmm_pkg::IDX_W-1:0]  out_col,
	output logic [sqmm_pkg::DATA_W-1:0] product_value,
	output logic                       saturated,
	output logic                       last_element
);

	import sqmm_pkg::*;

	logic              wr_in_range;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr_first;
	logic [ADDR_W-1:0] raddr_second;
	logic [DATA_W-1:0] rdata_first;
	logic [DATA_W-1:0] rdata_second;
	logic              rd_valid_s1;
	logic              mul_valid_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  shifted;
	logic [ACC_W-32:0] shifted_hi;
	logic              sat;
	logic [DATA_W-1:0] sat_value;

	assign wr_in_range = (DIM_W'(wr_row) < DIM_W'(MAX_DIM)) &&
	                     (DIM_W'(wr_col) < DIM_W'(MAX_DIM));
	assign waddr        = ADDR_W'(wr_row) * ADDR_W'(MAX_DIM) + ADDR_W'(wr_col);
	assign raddr_first  = ADDR_W'(cmd.r) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.k);
	assign raddr_second = ADDR_W'(cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.c);

	sqmm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_first_ram (
		.clk  (clk),
		.we   (cmd.wr_first && wr_in_range),
		.waddr(waddr),
		.wdata(wr_data),
		.raddr(raddr_first),
		.rdata(rdata_first)
	);

	sqmm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_second_ram (
		.clk  (clk),
		.we   (cmd.wr_second && wr_in_range),
		.waddr(waddr),
		.wdata(wr_data),
		.raddr(raddr_second),
		.rdata(rdata_second)
	);

	assign stat.pipe_busy = rd_valid_s1 || mul_valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1  <= 1'b0;
			mul_valid_s2 <= 1'b0;
		end else begin
			rd_valid_s1  <= cmd.issue;
			mul_valid_s2 <= rd_valid_s1;
		end
	end

	// full-width signed product, operands sign-extended by the 64-bit target
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(rdata_first) * $signed(rdata_second);
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (mul_valid_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// floor shift, then clip when the bits above the result are not all sign
	assign shifted    = $signed(acc_q) >>> FRAC_BITS;
	assign shifted_hi = shifted[ACC_W-1:31];
	assign sat        = !((&shifted_hi) || !(|shifted_hi));
	assign sat_value  = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
	                                     : {1'b0, {(DATA_W-1){1'b1}}};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_row       <= cmd.r;
			out_col       <= cmd.c;
			product_value <= sat ? sat_value : shifted[DATA_W-1:0];
			saturated     <= sat;
			last_element  <= cmd.last;
		end
	end

endmodule

// File: tb/testbench.sv
// self-checking testbench for the square matrix multiplier: directed and random load/compute traffic
`timescale 1ns / 1ps

module testbench;
	import sqmm_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int TARGET_BEATS = 500;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
		logic              sat;
		logic              last;
	} product_beat_t;

	class product_scoreboard;
		logic signed [DATA_W-1:0] first_store [STORE_DEPTH];
		logic signed [DATA_W-1:0] second_store [STORE_DEPTH];
		logic [DIM_W-1:0] size_reg;
		product_beat_t expected_q [$];
		int mismatches;
		int checked;
		int sat_seen;

		function new();
			size_reg = SIZE_RESET;
			mismatches = 0;
			checked = 0;
			sat_seen = 0;
			foreach (first_store[i]) begin
				first_store[i] = '0;
				second_store[i] = '0;
			end
		endfunction

		function void set_size(logic [DIM_W-1:0] v);
			size_reg = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// predicts the product beats caused by one accepted input beat
		function void note_input(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
				logic [IDX_W-1:0] col, logic [DATA_W-1:0] value);
			int n, r, c, k;
			logic signed [67:0] acc;
			logic signed [67:0] shifted;
			product_beat_t beat;
			case (req)
				REQ_WR_FIRST: begin
					first_store[row * MAX_DIM + col] = value;
				end
				REQ_WR_SECOND: begin
					second_store[row * MAX_DIM + col] = value;
				end
				REQ_COMPUTE: begin
					n = int'(size_reg);
					if (n < 1) n = 1;
					if (n > MAX_DIM) n = MAX_DIM;
					for (r = 0; r < n; r++) begin
						for (c = 0; c < n; c++) begin
							acc = '0;
							for (k = 0; k < n; k++)
								acc += first_store[r * MAX_DIM + k] * second_store[k * MAX_DIM + c];
							// arithmetic shift rounds toward minus infinity
							shifted = acc >>> FRAC_BITS;
							beat.row = r[IDX_W-1:0];
							beat.col = c[IDX_W-1:0];
							beat.sat = 1'b1;
							if (shifted > 68'sh7FFFFFFF)
								beat.value = 32'h7FFFFFFF;
							else if (shifted < -68'sh80000000)
								beat.value = 32'h80000000;
							else begin
								beat.value = shifted[DATA_W-1:0];
								beat.sat = 1'b0;
							end
							beat.last = (r == n - 1) && (c == n - 1);
							expected_q.push_back(beat);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(product_beat_t got);
			product_beat_t want;
			checked++;
			if (got.sat) sat_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected product beat row %0d col %0d value %h sat %b last %b",
						$time, got.row, got.col, got.value, got.sat, got.last);
				return;
			end
			want = expected_q.pop_front();
			if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
					got.sat !== want.sat || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: product mismatch exp r%0d c%0d %h sat %b last %b, got r%0d c%0d %h sat %b last %b",
						$time, want.row, want.col, want.value, want.sat, want.last,
						got.row, got.col, got.value, got.sat, got.last);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [REQ_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [DIM_W-1:0]       cfg_wdata;

	product_scoreboard sb = new();

	bit first_written [STORE_DEPTH];
	bit second_written [STORE_DEPTH];
	logic [DIM_W-1:0] cur_size = SIZE_RESET;
	int beats_sent = 0;
	int computes_sent = 0;
	int cycles = 0;
	int rx_hold = 0;
	int rx_stall = 0;
	bit rx_steady = 0;
	bit tx_steady = 0;

	square_matrix_multiply DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tuser, m_tlast});
	end

	// result side: random stalls, steady stretches and a requested long hold
	initial begin
		int pick;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready = 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				m_tready = 1'b0;
				rx_stall--;
			end else if (rx_steady) begin
				m_tready = 1'b1;
			end else begin
				pick = $urandom_range(99);
				m_tready = (pick < 70);
				if (pick >= 70 && pick < 95)
					rx_stall = $urandom_range(2, 0);
				else if (pick >= 95)
					rx_stall = $urandom_range(40, 10);
			end
		end
	end

	function automatic int eff_dim(logic [DIM_W-1:0] v);
		if (v < 1) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic int pick_gap();
		int p;
		if (tx_steady) return 0;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int p;
		logic [DATA_W-1:0] v;
		p = $urandom_range(99);
		if (p < 10) begin
			case ($urandom_range(5))
				0: v = 32'h80000000;
				1: v = 32'h7FFFFFFF;
				2: v = 32'h00000000;
				3: v = 32'hFFFFFFFF;
				4: v = 32'h00010000;
				default: v = 32'hFFFF0000;
			endcase
		end else if (p < 45) begin
			// values between -16 and 16 units in Q16.16, so sums stay in range
			v = $urandom_range(32'h1FFFFF, 0);
			v = v - 32'h00100000;
		end else if (p < 70) begin
			v = $urandom_range(32'hFFFFFF, 0);
			v = v - 32'h00800000;
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	task automatic send_beat(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value, input int gap);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {4'b0, value, col, row};
		do @(posedge clk); while (!s_tready);
		sb.note_input(req, row, col, value);
		if (req != REQ_UNUSED) beats_sent++;
		if (req == REQ_COMPUTE) computes_sent++;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_value(input logic [REQ_W-1:0] which, input int r, input int c,
			input logic [DATA_W-1:0] value, input int gap);
		send_beat(which, r[IDX_W-1:0], c[IDX_W-1:0], value, gap);
		if (which == REQ_WR_FIRST)
			first_written[r * MAX_DIM + c] = 1'b1;
		else
			second_written[r * MAX_DIM + c] = 1'b1;
	endtask

	// a compute may only read entries loaded since reset
	task automatic compute_product(input int gap);
		int n;
		n = eff_dim(cur_size);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				if (!first_written[r * MAX_DIM + c])
					write_value(REQ_WR_FIRST, r, c, pick_value(), pick_gap());
				if (!second_written[r * MAX_DIM + c])
					write_value(REQ_WR_SECOND, r, c, pick_value(), pick_gap());
			end
		send_beat(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom), gap);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic set_matrix_size(input logic [DIM_W-1:0] v);
		wait_drained();
		// let a trailing load beat settle before touching the size
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_size(v);
		cur_size = v;
	endtask

	task automatic run_phase(input logic [DIM_W-1:0] size_val, input int len);
		int p, n;
		set_matrix_size(size_val);
		n = eff_dim(size_val);
		rx_steady = ($urandom_range(4) == 0);
		tx_steady = ($urandom_range(4) == 0);
		for (int i = 0; i < len; i++) begin
			p = $urandom_range(99);
			if (p < 78) begin
				if ($urandom_range(4) != 0)
					write_value(REQ_W'($urandom_range(1)), $urandom_range(n - 1),
						$urandom_range(n - 1), pick_value(), pick_gap());
				else
					write_value(REQ_W'($urandom_range(1)), $urandom_range(3), $urandom_range(3),
						pick_value(), pick_gap());
			end else if (p < 94) begin
				compute_product(pick_gap());
			end else if (p < 97) begin
				send_beat(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom),
					pick_gap());
			end else begin
				wait_drained();
			end
		end
		compute_product(pick_gap());
	endtask

	initial begin
		logic [DIM_W-1:0] sweep [6];
		sweep = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_WR_FIRST;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: one by one products at the value extremes
		set_matrix_size(3'd1);
		write_value(REQ_WR_FIRST, 0, 0, 32'h80000000, 0);
		write_value(REQ_WR_SECOND, 0, 0, 32'h80000000, 1);
		send_beat(REQ_COMPUTE, 2'd3, 2'd3, 32'hFFFFFFFF, 0);
		write_value(REQ_WR_SECOND, 0, 0, 32'h7FFFFFFF, 0);
		send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'h0, 2);
		write_value(REQ_WR_FIRST, 0, 0, 32'hFFFFFFFF, 0);
		write_value(REQ_WR_SECOND, 0, 0, 32'h00000001, 0);
		send_beat(REQ_COMPUTE, 2'd1, 2'd2, 32'h12345678, 0);
		write_value(REQ_WR_FIRST, 0, 0, 32'h7FFFFFFF, 0);
		send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'h0, 3);
		send_beat(REQ_UNUSED, 2'd3, 2'd3, 32'hFFFFFFFF, 0);
		write_value(REQ_WR_FIRST, 3, 3, 32'h7FFFFFFF, 0);
		write_value(REQ_WR_SECOND, 3, 3, 32'h80000000, 0);
		// size zero behaves as one
		set_matrix_size(3'd0);
		send_beat(REQ_COMPUTE, 2'd3, 2'd3, 32'h0, 0);
		set_matrix_size(3'd2);
		write_value(REQ_WR_FIRST, 0, 1, 32'h00010000, 0);
		write_value(REQ_WR_FIRST, 1, 0, 32'hFFFF0000, 0);
		write_value(REQ_WR_FIRST, 1, 1, 32'h00008000, 0);
		write_value(REQ_WR_SECOND, 0, 1, 32'h00020000, 0);
		write_value(REQ_WR_SECOND, 1, 0, 32'hFFFE8000, 0);
		write_value(REQ_WR_SECOND, 1, 1, 32'h00000003, 0);
		send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'h0, 0);

		foreach (sweep[i]) run_phase(sweep[i], $urandom_range(45, 30));

		// back pressure: output held off while loads keep coming behind a full compute
		set_matrix_size(3'd4);
		rx_steady = 1'b0;
		tx_steady = 1'b1;
		@(posedge clk);
		rx_hold = 300;
		compute_product(0);
		for (int i = 0; i < 20; i++)
			write_value(REQ_W'($urandom_range(1)), $urandom_range(3), $urandom_range(3),
				pick_value(), 0);
		compute_product(0);
		wait_drained();

		while (beats_sent < TARGET_BEATS)
			run_phase(DIM_W'($urandom_range(7)), $urandom_range(50, 20));

		wait_drained();
		repeat (40) @(posedge clk);
		$display("stimulus: %0d load/compute beats, %0d product requests, sizes 0 to 7",
			beats_sent, computes_sent);
		$display("results: %0d product beats checked, %0d saturated, %0d mismatches",
			sb.checked, sb.sat_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: square_matrix_multiply.f
rtl/sqmm_pkg.sv
rtl/sqmm_ram.sv
rtl/sqmm_ctrl.sv
rtl/sqmm_datapath.sv
rtl/square_matrix_multiply.sv
tb/testbench.sv
